// ===== rtl/dsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared constants and types for the DAG shortest-path block.
// ----------------------------------------------------------------------------
package dsp_pkg;
	localparam int MaxNodesDef   = 32;
	localparam int MaxEdgesDef   = 256;
	localparam int WeightBitsDef = 16;

	localparam logic [1:0] CMD_ADD     = 2'd0;
	localparam logic [1:0] CMD_COMPUTE = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic [31:0] DIST_INF = 32'h7FFF_FFFF;
	localparam logic [5:0]  NODE_COUNT_RESET = 6'd32;

	localparam logic [0:0] REG_NODE_COUNT = 1'd0;

	// Controller to datapath.
	typedef struct packed {
		logic clr_work;    // clear visited, reached, stack, order
		logic seed;        // push root_q as a new search root unless visited
		logic scan;        // examine edge at edge cursor during search
		logic pop;         // finish top of stack
		logic set_src;
		logic relax;       // relax edge for current topo node
		logic next_topo;   // step to the next node in topological order
		logic emit;        // produce one result row
	} dsp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic stack_empty;
		logic edge_end;     // cursor reached edge_total
		logic root_done;
		logic topo_done;
		logic node_skip;
		logic emit_done;
	} dsp_sts_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return s[31:0];
	endfunction
endpackage

// ===== rtl/dsp_if.sv =====
// ----------------------------------------------------------------------------
// dsp_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface dsp_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dsp_ram.sv =====
// ----------------------------------------------------------------------------
// dsp_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsp_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/dsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsp_ctrl
// Sequencer for the clear, search, relaxation and report phases.
// ----------------------------------------------------------------------------
module dsp_ctrl
	import dsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  dsp_sts_t   sts,
	output dsp_cmd_t   cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_ROOT  = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_SRC   = 4'd5;
	localparam logic [3:0] S_TNODE = 4'd6;
	localparam logic [3:0] S_RRD   = 4'd7;
	localparam logic [3:0] S_REL   = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: if (start) state_d = S_CLR;
			S_CLR: begin
				cmd.clr_work = 1'b1;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				if (sts.root_done) state_d = S_SRC;
				else begin
					cmd.seed = 1'b1;
					state_d = S_RD;
				end
			end
			// Spacer state between one search step and the next.
			S_RD: state_d = S_SCAN;
			S_SCAN: begin
				if (sts.stack_empty) state_d = S_ROOT;
				else if (sts.edge_end) begin
					cmd.pop = 1'b1;
					state_d = S_RD;
				end else begin
					cmd.scan = 1'b1;
					state_d = S_RD;
				end
			end
			S_SRC: begin
				cmd.set_src = 1'b1;
				state_d = S_TNODE;
			end
			S_TNODE: begin
				if (sts.topo_done) state_d = S_EMIT;
				else state_d = S_RRD;
			end
			S_RRD: state_d = S_REL;
			S_REL: begin
				if (sts.node_skip || sts.edge_end) begin
					cmd.next_topo = 1'b1;
					state_d = S_TNODE;
				end else begin
					cmd.relax = 1'b1;
					state_d = S_RRD;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// ===== rtl/dsp_dpath.sv =====
// ----------------------------------------------------------------------------
// dsp_dpath
// Edge table, search stack, topological order, distances and result rows.
// ----------------------------------------------------------------------------
module dsp_dpath
	import dsp_pkg::*;
#(
	parameter int MaxNodes   = MaxNodesDef,
	parameter int MaxEdges   = MaxEdgesDef,
	parameter int WeightBits = WeightBitsDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dsp_cmd_t              cmd,
	output dsp_sts_t              sts,
	input  logic                  add_we,
	input  logic                  clr_edges,
	input  logic [4:0]            add_from,
	input  logic [4:0]            add_to,
	input  logic [WeightBits-1:0] add_weight,
	input  logic [4:0]            src_in,
	input  logic                  src_load,
	input  logic [5:0]            node_count,
	output logic                  full,
	input  logic                  out_hold,
	output logic                  row_valid,
	output logic [4:0]            row_node,
	output logic [31:0]           row_dist,
	output logic                  row_reach,
	output logic                  row_last
);
	localparam int NW = $clog2(MaxNodes);
	localparam int EW = $clog2(MaxEdges);
	localparam int EntW = 10 + WeightBits;

	logic [EW:0]  edge_total_q;
	logic [EW:0]  cur_q;           // edge cursor
	logic [EW:0]  cur_d;
	logic [EntW-1:0] rd;
	logic [4:0]   e_from, e_to;
	logic [WeightBits-1:0] e_w;

	logic [MaxNodes-1:0] visited_q, reached_q;
	logic [31:0] dist_q [MaxNodes];
	logic [NW-1:0] stk_node_q [MaxNodes];
	logic [EW:0]   stk_cur_q [MaxNodes];
	logic [NW:0]   depth_q;
	logic [NW-1:0] topo_q [MaxNodes];
	logic [NW:0]   topo_len_q, tk_q;
	logic [NW:0]   root_q, emit_q, n_eff;
	logic [4:0]    src_q;
	logic [NW-1:0] top_node;
	logic [NW-1:0] tnode;
	logic          to_ok;

	assign full = edge_total_q >= (EW+1)'(MaxEdges);
	assign n_eff = (node_count == 6'd0) ? (NW+1)'(1) :
		(32'(node_count) > MaxNodes) ? (NW+1)'(MaxNodes) : (NW+1)'(node_count);

	dsp_ram #(.Width(EntW), .Depth(MaxEdges)) u_edges (
		.clk(clk), .we(add_we && !full), .waddr(edge_total_q[EW-1:0]),
		.wdata({add_from, add_to, add_weight}), .raddr(cur_d[EW-1:0]), .rdata(rd)
	);
	assign {e_from, e_to, e_w} = rd;
	assign to_ok = (32'(e_to) < MaxNodes);

	assign top_node = stk_node_q[depth_q[NW-1:0] - NW'(1)];
	assign tnode = topo_q[tk_q[NW-1:0] - NW'(1)];

	assign sts.stack_empty = (depth_q == '0);
	assign sts.edge_end = (cur_q >= edge_total_q);
	assign sts.root_done = (root_q >= n_eff);
	assign sts.topo_done = (tk_q == '0);
	assign sts.node_skip = !reached_q[tnode];
	assign sts.emit_done = (emit_q == n_eff - (NW+1)'(1)) && !out_hold;

	logic take, rel_ok;
	logic [31:0] cand;
	assign take = cmd.scan && (32'(e_from) == 32'(top_node)) && to_ok
		&& !visited_q[e_to[NW-1:0]] && (32'(depth_q) < MaxNodes);
	assign cand = sat_add(dist_q[tnode], 32'($signed(e_w)));
	assign rel_ok = cmd.relax && (32'(e_from) == 32'(tnode)) && to_ok;

	// The next cursor drives the RAM read address, so the edge at the cursor is
	// on rd in the same cycle as the cursor register holds it.
	always_comb begin
		cur_d = cur_q;
		if (cmd.seed) cur_d = '0;
		else if (take) cur_d = '0;
		else if (cmd.scan) cur_d = cur_q + 1'b1;
		else if (cmd.pop) cur_d = (depth_q > (NW+1)'(1)) ?
			stk_cur_q[depth_q[NW-1:0] - NW'(2)] : '0;
		else if (cmd.set_src) cur_d = '0;
		else if (cmd.relax) cur_d = cur_q + 1'b1;
		else if (cmd.next_topo) cur_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			cur_q <= '0;
			visited_q <= '0;
			reached_q <= '0;
			depth_q <= '0;
			topo_len_q <= '0;
			tk_q <= '0;
			root_q <= '0;
			emit_q <= '0;
			row_valid <= 1'b0;
		end else begin
			if (clr_edges) edge_total_q <= '0;
			else if (add_we && !full) edge_total_q <= edge_total_q + 1'b1;
			cur_q <= cur_d;
			if (cmd.clr_work) begin
				visited_q <= '0;
				reached_q <= '0;
				depth_q <= '0;
				topo_len_q <= '0;
				root_q <= '0;
				emit_q <= '0;
			end
			if (cmd.seed) begin
				if (!visited_q[root_q[NW-1:0]]) begin
					visited_q[root_q[NW-1:0]] <= 1'b1;
					stk_node_q[0] <= root_q[NW-1:0];
					depth_q <= (NW+1)'(1);
				end
				root_q <= root_q + 1'b1;
			end
			if (take) begin
				visited_q[e_to[NW-1:0]] <= 1'b1;
				stk_cur_q[depth_q[NW-1:0] - NW'(1)] <= cur_q + 1'b1;
				stk_node_q[depth_q[NW-1:0]] <= e_to[NW-1:0];
				depth_q <= depth_q + 1'b1;
			end
			if (cmd.pop) begin
				topo_q[topo_len_q[NW-1:0]] <= top_node;
				topo_len_q <= topo_len_q + 1'b1;
				depth_q <= depth_q - 1'b1;
			end
			if (cmd.set_src) begin
				tk_q <= topo_len_q;
				if (32'(src_q) < MaxNodes) begin
					reached_q[src_q[NW-1:0]] <= 1'b1;
					dist_q[src_q[NW-1:0]] <= '0;
				end
			end
			if (rel_ok) begin
				if (!reached_q[e_to[NW-1:0]] || $signed(cand) < $signed(dist_q[e_to[NW-1:0]]))
				begin
					dist_q[e_to[NW-1:0]] <= cand;
					reached_q[e_to[NW-1:0]] <= 1'b1;
				end
			end
			if (cmd.emit && !out_hold) begin
				row_valid <= 1'b1;
				row_node <= 5'(emit_q);
				row_reach <= reached_q[emit_q[NW-1:0]];
				row_dist <= reached_q[emit_q[NW-1:0]] ? dist_q[emit_q[NW-1:0]] : DIST_INF;
				row_last <= (emit_q == n_eff - (NW+1)'(1));
				emit_q <= emit_q + 1'b1;
			end else if (!out_hold) row_valid <= 1'b0;
			if (src_load) src_q <= src_in;
			// Move to the next topo node once this one's edges are spent or it is unreached.
			if (cmd.next_topo) begin
				tk_q <= tk_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/dag_shortest_path.sv =====
// ----------------------------------------------------------------------------
// dag_shortest_path
// Single-source shortest paths over a weighted DAG by topological sort.
// ----------------------------------------------------------------------------
// Add-edge and clear commands accept one beat per cycle while no compute runs
// and no result beat is on the output; a full edge table answers with a status
// beat, and no further command is taken until that beat has gone. A compute
// command runs a depth-first search, then a relaxation pass, each stepping
// through the edge table one entry at a time. The search visits at most
// MaxNodes nodes, more than the N reported nodes where edges lead past
// node_count. The N result beats then leave one per cycle unless the receiver
// stalls, and the next command is taken once the last beat has been accepted.
module dag_shortest_path
	import dsp_pkg::*;
#(
	parameter int MaxNodes   = MaxNodesDef,
	parameter int MaxEdges   = MaxEdgesDef,
	parameter int WeightBits = WeightBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [4:0]  from_node,
	input  logic [4:0]  to_node,
	input  logic [WeightBits-1:0] weight,
	input  logic [4:0]  source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  node,
	output logic [31:0] distance,
	output logic        reachable,
	output logic        status,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	dsp_cmd_t cmd;
	dsp_sts_t sts;
	logic busy, full, acc, rej_q, row_valid, row_reach, row_last;
	logic [4:0] row_node;
	logic [31:0] row_dist;
	logic [5:0] node_count_q;

	assign pready = 1'b1;
	assign prdata = {26'd0, node_count_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= NODE_COUNT_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT)
			node_count_q <= pwdata[5:0];
	end

	assign in_ready = !busy && !rej_q && !(row_valid);
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rej_q <= 1'b0;
		else if (acc && command == CMD_ADD && full) rej_q <= 1'b1;
		else if (out_ready) rej_q <= 1'b0;
	end

	dsp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(acc && command == CMD_COMPUTE),
		.busy(busy), .sts(sts), .cmd(cmd)
	);

	dsp_dpath #(.MaxNodes(MaxNodes), .MaxEdges(MaxEdges), .WeightBits(WeightBits)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.add_we(acc && command == CMD_ADD), .clr_edges(acc && command == CMD_CLEAR),
		.add_from(from_node), .add_to(to_node), .add_weight(weight),
		.src_in(source), .src_load(acc && command == CMD_COMPUTE),
		.node_count(node_count_q), .full(full), .out_hold(row_valid && !out_ready),
		.row_valid(row_valid), .row_node(row_node), .row_dist(row_dist),
		.row_reach(row_reach), .row_last(row_last)
	);

	assign out_valid = row_valid || rej_q;
	assign node = rej_q ? 5'd0 : row_node;
	assign distance = rej_q ? 32'd0 : row_dist;
	assign reachable = rej_q ? 1'b0 : row_reach;
	assign status = rej_q;
	assign last = rej_q ? 1'b0 : row_last;

`ifndef SYNTHESIS
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(rej_q && row_valid)) else $error("reject and row beat together");
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("input taken while busy");
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> !last) else $error("status beat marked last");
`endif
endmodule

// ===== dv/dsp_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_tb_pkg
// Beat layouts of the command and result channels used by the testbench.
// ----------------------------------------------------------------------------
package dsp_tb_pkg;
	// Command code that the block ignores.
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  from_node;
		logic [4:0]  to_node;
		logic [15:0] weight;
		logic [4:0]  source;
	} cmd_beat_t;

	typedef struct packed {
		logic [4:0]  node;
		logic [31:0] distance;
		logic        reachable;
		logic        status;
		logic        last;
	} row_beat_t;
endpackage

// ===== dv/dsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_checker
// Watches the command, result and register ports, keeps its own copy of the
// edge table and node count, works out the distance rows each command beat
// should produce and compares every result beat with the oldest of them.
// ----------------------------------------------------------------------------
module dsp_checker
	import dsp_pkg::*;
	import dsp_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  cmd_beat_t   in_beat,
	input  logic        out_valid,
	input  logic        out_ready,
	input  row_beat_t   out_beat,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          rows_pending,
	output int          fail_count
);
	logic [4:0]  tbl_from [MaxEdgesDef];
	logic [4:0]  tbl_to [MaxEdgesDef];
	int          tbl_weight [MaxEdgesDef];
	int          tbl_count;
	logic [5:0]  nodes_cfg;
	row_beat_t   expected_rows [$];
	int          errors;

	assign rows_pending = expected_rows.size();
	assign fail_count = errors;

	function automatic int clamp_add(input int a, input int b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (s < -64'sd2147483648) return 32'sh8000_0000;
		return int'(s);
	endfunction

	function automatic void solve_distances(input logic [4:0] src);
		bit         seen [MaxNodesDef];
		bit         hit [MaxNodesDef];
		int         best [MaxNodesDef];
		int         order [MaxNodesDef];
		int         stk_node [MaxNodesDef];
		int         stk_pos [MaxNodesDef];
		int         n, olen, depth, top, cur, e, t, d, cand;
		bit         pushed;
		row_beat_t  r;
		n = (nodes_cfg == 0) ? 1 : (nodes_cfg > MaxNodesDef) ? MaxNodesDef : nodes_cfg;
		for (int i = 0; i < MaxNodesDef; i++) begin
			seen[i] = 0;
			hit[i] = 0;
			best[i] = 32'sh7FFF_FFFF;
		end
		olen = 0;
		for (int root = 0; root < n; root++) begin
			if (seen[root]) continue;
			seen[root] = 1;
			stk_node[0] = root;
			stk_pos[0] = 0;
			depth = 1;
			while (depth > 0) begin
				top = depth - 1;
				cur = stk_node[top];
				e = stk_pos[top];
				pushed = 0;
				while (e < tbl_count && !pushed) begin
					t = tbl_to[e];
					e++;
					if (tbl_from[e-1] == cur && !seen[t] && depth < MaxNodesDef) begin
						stk_pos[top] = e;
						seen[t] = 1;
						stk_node[depth] = t;
						stk_pos[depth] = 0;
						depth++;
						pushed = 1;
					end
				end
				if (!pushed) begin
					if (olen < MaxNodesDef) begin
						order[olen] = cur;
						olen++;
					end
					depth--;
				end
			end
		end
		best[src] = 0;
		hit[src] = 1;
		for (int k = olen; k > 0; k--) begin
			t = order[k-1];
			if (!hit[t]) continue;
			for (int j = 0; j < tbl_count; j++) begin
				if (tbl_from[j] != t) continue;
				d = tbl_to[j];
				cand = clamp_add(best[t], tbl_weight[j]);
				if (!hit[d] || cand < best[d]) begin
					best[d] = cand;
					hit[d] = 1;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			r.node = i[4:0];
			r.distance = hit[i] ? best[i] : DIST_INF;
			r.reachable = hit[i];
			r.status = 1'b0;
			r.last = (i == n - 1);
			expected_rows = {expected_rows, r};
		end
	endfunction

	function automatic void take_command(input cmd_beat_t b);
		row_beat_t r;
		case (b.command)
			CMD_ADD: begin
				if (tbl_count >= MaxEdgesDef) begin
					r = '0;
					r.status = 1'b1;
					expected_rows = {expected_rows, r};
				end else begin
					tbl_from[tbl_count] = b.from_node;
					tbl_to[tbl_count] = b.to_node;
					tbl_weight[tbl_count] = int'($signed(b.weight));
					tbl_count++;
				end
			end
			CMD_CLEAR: tbl_count = 0;
			CMD_COMPUTE: solve_distances(b.source);
			default: ;
		endcase
	endfunction

	function automatic void check_row(input row_beat_t got);
		row_beat_t want;
		if (expected_rows.size() == 0) begin
			$display("%0t: result beat with nothing expected: %p", $time, got);
			errors++;
			return;
		end
		want = expected_rows.pop_front();
		if (got.node !== want.node) begin
			$display("%0t: node expected %0d actual %0d", $time, want.node, got.node);
			errors++;
		end
		if (got.distance !== want.distance) begin
			$display("%0t: distance of node %0d expected %0d actual %0d", $time,
				want.node, $signed(want.distance), $signed(got.distance));
			errors++;
		end
		if (got.reachable !== want.reachable) begin
			$display("%0t: reachable of node %0d expected %0b actual %0b", $time,
				want.node, want.reachable, got.reachable);
			errors++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
			errors++;
		end
		if (got.last !== want.last) begin
			$display("%0t: last of node %0d expected %0b actual %0b", $time,
				want.node, want.last, got.last);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_count = 0;
			nodes_cfg = NODE_COUNT_RESET;
			errors = 0;
			expected_rows.delete();
		end else begin
			if (out_valid && out_ready) check_row(out_beat);
			if (in_valid && in_ready) take_command(in_beat);
			if (psel && penable && pwrite && pready && paddr == 3'(REG_NODE_COUNT) * 4)
				nodes_cfg = pwdata[5:0];
		end
	end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives edge, compute, clear and unknown commands and node-count writes into the
// shortest-path block under several idle and stall patterns; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
	import dsp_pkg::*;
	import dsp_tb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          rows_pending, fail_count;
	int          send_idle, recv_stall, edges_held;

	dsp_if #(.payload_t(cmd_beat_t)) cmd_ch ();
	dsp_if #(.payload_t(row_beat_t)) row_ch ();

	dag_shortest_path dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cmd_ch.valid), .in_ready(cmd_ch.ready),
		.command(cmd_ch.data.command), .from_node(cmd_ch.data.from_node),
		.to_node(cmd_ch.data.to_node), .weight(cmd_ch.data.weight),
		.source(cmd_ch.data.source),
		.out_valid(row_ch.valid), .out_ready(row_ch.ready),
		.node(row_ch.data.node), .distance(row_ch.data.distance),
		.reachable(row_ch.data.reachable), .status(row_ch.data.status),
		.last(row_ch.data.last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	dsp_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cmd_ch.valid), .in_ready(cmd_ch.ready), .in_beat(cmd_ch.data),
		.out_valid(row_ch.valid), .out_ready(row_ch.ready), .out_beat(row_ch.data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.rows_pending(rows_pending), .fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 20_000_000);
		$display("testbench: errors");
		$finish;
	end

	// The receiver decides its stall afresh at every falling edge.
	always @(negedge clk) row_ch.ready <= ($urandom_range(99) >= recv_stall);

	task automatic send(input logic [1:0] cmd, input logic [4:0] f, input logic [4:0] t,
			input logic [15:0] w, input logic [4:0] s);
		while ($urandom_range(99) < send_idle) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.data = '{command: cmd, from_node: f, to_node: t, weight: w, source: s};
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		if (cmd == CMD_ADD) edges_held++;
		if (cmd == CMD_CLEAR) edges_held = 0;
	endtask

	task automatic add_edge(input logic [4:0] f, input logic [4:0] t, input logic [15:0] w);
		send(CMD_ADD, f, t, w, 5'($urandom));
	endtask

	task automatic compute(input logic [4:0] s);
		send(CMD_COMPUTE, 5'($urandom), 5'($urandom), 16'($urandom), s);
	endtask

	task automatic drain;
		while (rows_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_nodes(input logic [31:0] value);
		drain();
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = 3'(REG_NODE_COUNT) * 4;
		pwdata = value;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic random_phase(input int items);
		int sent, k;
		sent = 0;
		while (sent < items) begin
			if (edges_held > 60 || $urandom_range(9) == 0) begin
				send(CMD_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
				sent++;
			end
			k = $urandom_range(12);
			repeat (k) begin
				// Mostly forward edges so that long paths form; some arbitrary ones.
				if ($urandom_range(3) != 0) begin
					int a, b;
					a = $urandom_range(30);
					b = $urandom_range(31, a + 1);
					add_edge(a[4:0], b[4:0], 16'($urandom_range(0, 3000) - 1000));
				end else
					add_edge(5'($urandom), 5'($urandom), 16'($urandom));
				sent++;
			end
			if ($urandom_range(15) == 0) begin
				send(CMD_UNKNOWN, 5'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
			end
			compute($urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(3)));
			sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		row_ch.ready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		edges_held = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty graph, field extremes, a cycle, unknown command.
		compute(5'd0);
		add_edge(5'd0, 5'd1, 16'h7FFF);
		add_edge(5'd1, 5'd31, 16'h8000);
		add_edge(5'd0, 5'd31, 16'h0001);
		add_edge(5'd31, 5'd0, 16'hFFFF);
		add_edge(5'd3, 5'd4, 16'd5);
		add_edge(5'd4, 5'd3, 16'd7);
		add_edge(5'd2, 5'd2, 16'd9);
		add_edge(5'd1, 5'd2, 16'h5555);
		add_edge(5'd2, 5'd3, 16'hAAAA);
		compute(5'd0);
		compute(5'd31);
		compute(5'd3);
		send(CMD_UNKNOWN, 5'd31, 5'd31, 16'hFFFF, 5'd31);
		set_nodes(32'd1);
		compute(5'd0);
		set_nodes(32'd0);
		compute(5'd1);
		set_nodes(32'hFFFF_FFE3);
		compute(5'd2);
		set_nodes(32'd4);
		compute(5'd0);
		send(CMD_CLEAR, 5'd0, 5'd0, 16'd0, 5'd0);
		compute(5'd31);
		set_nodes(32'd32);

		// Fill the table, then one more edge must come back rejected.
		recv_stall = 30;
		while (edges_held < MaxEdgesDef)
			add_edge(5'($urandom), 5'($urandom), 16'($urandom));
		add_edge(5'd5, 5'd6, 16'd1);
		compute(5'($urandom));
		send(CMD_CLEAR, 5'd0, 5'd0, 16'd0, 5'd0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle = (phase == 1 || phase == 3) ? ((phase == 3) ? 27 : 64) : 0;
			recv_stall = (phase == 2 || phase == 3) ? ((phase == 3) ? 27 : 64) : 0;
			set_nodes(phase == 0 ? 32'd32 : phase == 1 ? 32'd40 :
				32'($urandom_range(1, 32)));
			random_phase(40);
		end

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && rows_pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

// ===== dag_shortest_path.f =====
rtl/dsp_pkg.sv
rtl/dsp_if.sv
rtl/dsp_ram.sv
rtl/dsp_ctrl.sv
rtl/dsp_dpath.sv
rtl/dag_shortest_path.sv
dv/dsp_tb_pkg.sv
dv/dsp_checker.sv
dv/testbench.sv
